[rtl/twcp_pkg.sv]
// shared types and constants for the textured wall column pixel pipeline
// no dependencies
`default_nettype none

package twcp_pkg;

    localparam int TILE            = 64;
    localparam int TILE_BITS       = $clog2(TILE);
    localparam int BYTES_PER_PIXEL = 4;

    localparam int ROW_W    = 11;
    localparam int SPAN_W   = 16;
    localparam int TEX_W    = 16;
    localparam int COLOR_W  = 24;
    localparam int LINE_W   = 16;
    localparam int FB_W     = 27;
    localparam int FACE_W   = 2;
    localparam int PACK_W   = 64;
    localparam int CFG_IDX_W = 3;

    // span and row offset both fit in 17 bits
    localparam int DIFF_W = 17;
    localparam int PROD_W = DIFF_W + TEX_W;

    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = TEX_W / DIV_STEPS;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_WIDTHS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_HEIGHTS = 3'd5;

    localparam logic [ROW_W-1:0]   RST_SCREEN_ROWS = 11'd480;
    localparam logic [LINE_W-1:0]  RST_LINE_BYTES  = 16'd2560;
    localparam logic [PACK_W-1:0]  RST_FACE_DIMS   = 64'h0040_0040_0040_0040;

    localparam logic [1:0] REGION_CEILING = 2'd0;
    localparam logic [1:0] REGION_WALL    = 2'd1;
    localparam logic [1:0] REGION_FLOOR   = 2'd2;

    typedef struct packed {
        logic [1:0]         region;
        logic [COLOR_W-1:0] fill;
        logic [FACE_W-1:0]  face;
        logic [TEX_W-1:0]   tcol;
        logic [FB_W-1:0]    fb;
        logic [TEX_W-1:0]   ht;
        logic               sat;
    } t_side;

    typedef struct packed {
        logic [DIFF_W-1:0] rem;
        logic [TEX_W-1:0]  lo;
        logic [TEX_W-1:0]  q;
        logic [DIFF_W-1:0] span;
    } t_div;

endpackage

`default_nettype wire

[rtl/textured_wall_column_pixel.sv]
// textured wall column pixel: span, row class, texel coordinates, fb offset
// depends on twcp_pkg
// one item per cycle sustained while the output is not stalled
// the texel row divider takes two quotient bits per stage over eight stages
// the whole pipeline holds while a result waits under output stall
// reset clears all valid bits and loads the register defaults
`default_nettype none

module textured_wall_column_pixel (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [twcp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [twcp_pkg::PACK_W-1:0]          i_cfg_data,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [twcp_pkg::ROW_W-1:0]           i_column,
    input  wire logic [twcp_pkg::ROW_W-1:0]           i_row,
    input  wire logic [twcp_pkg::SPAN_W-1:0]          i_wall_span,
    input  wire logic [twcp_pkg::FACE_W-1:0]          i_face,
    input  wire logic signed [twcp_pkg::TEX_W-1:0]    i_hit_coord,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic [1:0]                                o_region,
    output logic [twcp_pkg::COLOR_W-1:0]              o_fill_color,
    output logic [twcp_pkg::FACE_W-1:0]               o_tex_face,
    output logic [twcp_pkg::TEX_W-1:0]                o_tex_col,
    output logic [twcp_pkg::TEX_W-1:0]                o_tex_row,
    output logic [twcp_pkg::FB_W-1:0]                 o_fb_offset
);

    localparam int NS = twcp_pkg::DIV_STAGES;
    localparam int DW = twcp_pkg::DIFF_W;
    localparam int TW = twcp_pkg::TEX_W;

    // configuration registers
    logic [twcp_pkg::ROW_W-1:0]   r_screen_rows;
    logic [twcp_pkg::COLOR_W-1:0] r_ceiling;
    logic [twcp_pkg::COLOR_W-1:0] r_floor;
    logic [twcp_pkg::LINE_W-1:0]  r_line;
    logic [twcp_pkg::PACK_W-1:0]  r_widths;
    logic [twcp_pkg::PACK_W-1:0]  r_heights;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_rows <= twcp_pkg::RST_SCREEN_ROWS;
            r_ceiling     <= '0;
            r_floor       <= '0;
            r_line        <= twcp_pkg::RST_LINE_BYTES;
            r_widths      <= twcp_pkg::RST_FACE_DIMS;
            r_heights     <= twcp_pkg::RST_FACE_DIMS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                twcp_pkg::CFG_SCREEN_ROWS:  r_screen_rows <= i_cfg_data[twcp_pkg::ROW_W-1:0];
                twcp_pkg::CFG_CEILING:      r_ceiling <= i_cfg_data[twcp_pkg::COLOR_W-1:0];
                twcp_pkg::CFG_FLOOR:        r_floor <= i_cfg_data[twcp_pkg::COLOR_W-1:0];
                twcp_pkg::CFG_LINE_BYTES:   r_line <= i_cfg_data[twcp_pkg::LINE_W-1:0];
                twcp_pkg::CFG_FACE_WIDTHS:  r_widths <= i_cfg_data;
                twcp_pkg::CFG_FACE_HEIGHTS: r_heights <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // pipeline advance
    logic r_out_valid;
    logic w_en;

    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = !w_en;

    // stage 1: span limits
    logic                              r1_valid;
    logic [twcp_pkg::ROW_W-1:0]        r1_column;
    logic [twcp_pkg::ROW_W-1:0]        r1_row;
    logic [twcp_pkg::FACE_W-1:0]       r1_face;
    logic [TW-1:0]                     r1_hit;
    logic signed [DW-1:0]              r1_top;
    logic [TW-1:0]                     r1_bottom;
    logic signed [DW:0]                n1_d;
    logic signed [DW:0]                n1_half;
    logic [DW-1:0]                     n1_sum;

    always_comb begin
        n1_d    = $signed({7'b0, r_screen_rows}) - $signed({2'b0, i_wall_span});
        // truncate toward zero
        n1_half = (n1_d + $signed({{DW{1'b0}}, n1_d[DW]})) >>> 1;
        n1_sum  = {6'b0, r_screen_rows} + {1'b0, i_wall_span};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_column <= i_column;
            r1_row    <= i_row;
            r1_face   <= i_face;
            r1_hit    <= i_hit_coord;
            r1_top    <= n1_half[DW-1:0];
            r1_bottom <= n1_sum[DW-1:1];
        end
    end

    // stage 2: classify, texel column, offset
    logic                         r2_valid;
    logic [1:0]                   r2_region;
    logic [twcp_pkg::COLOR_W-1:0] r2_fill;
    logic [twcp_pkg::FACE_W-1:0]  r2_face;
    logic [TW-1:0]                r2_tcol;
    logic [twcp_pkg::FB_W-1:0]    r2_fb;
    logic [DW-1:0]                r2_diff;
    logic [DW-1:0]                r2_span;
    logic [TW-1:0]                r2_ht;

    logic [1:0]                   n2_region;
    logic [twcp_pkg::COLOR_W-1:0] n2_fill;
    logic [TW-1:0]                n2_w;
    logic [TW-1:0]                n2_ht;
    logic [twcp_pkg::TILE_BITS+TW-1:0] n2_cprod;
    logic [TW-1:0]                n2_tcol;
    logic [DW:0]                  n2_diff;
    logic [DW:0]                  n2_span;
    logic [twcp_pkg::FB_W-1:0]    n2_fb;

    always_comb begin
        n2_w     = r_widths[{r1_face, 4'b0} +: TW];
        n2_ht    = r_heights[{r1_face, 4'b0} +: TW];
        n2_cprod = (twcp_pkg::TILE_BITS+TW)'(r1_hit[twcp_pkg::TILE_BITS-1:0])
                 * (twcp_pkg::TILE_BITS+TW)'(n2_w);
        n2_tcol  = r1_hit[TW-1] ? '0 : n2_cprod[twcp_pkg::TILE_BITS +: TW];
        n2_diff  = (DW+1)'($signed({7'b0, r1_row}) - $signed({r1_top[DW-1], r1_top}));
        n2_span  = (DW+1)'($signed({2'b0, r1_bottom}) - $signed({r1_top[DW-1], r1_top}));
        n2_fb    = twcp_pkg::FB_W'(r1_row) * twcp_pkg::FB_W'(r_line)
                 + twcp_pkg::FB_W'(r1_column) * twcp_pkg::FB_W'(twcp_pkg::BYTES_PER_PIXEL);
        priority if ($signed({7'b0, r1_row}) < $signed({r1_top[DW-1], r1_top})) begin
            n2_region = twcp_pkg::REGION_CEILING;
            n2_fill   = r_ceiling;
        end else if ({5'b0, r1_row} <= r1_bottom) begin
            n2_region = twcp_pkg::REGION_WALL;
            n2_fill   = '0;
        end else begin
            n2_region = twcp_pkg::REGION_FLOOR;
            n2_fill   = r_floor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_region <= n2_region;
            r2_fill   <= n2_fill;
            r2_face   <= r1_face;
            r2_tcol   <= n2_tcol;
            r2_fb     <= n2_fb;
            r2_diff   <= n2_diff[DW-1:0];
            r2_span   <= n2_span[DW-1:0];
            r2_ht     <= n2_ht;
        end
    end

    // stage 3: product and saturation, then divider stages
    logic             r_vl [0:NS];
    twcp_pkg::t_side  r_sd [0:NS];
    twcp_pkg::t_div   r_dv [0:NS];
    twcp_pkg::t_side  n3_sd;
    twcp_pkg::t_div   n3_dv;
    logic [twcp_pkg::PROD_W-1:0] n3_prod;
    twcp_pkg::t_div   n_dv [0:NS-1];
    logic [DW:0]      v_t;

    always_comb begin
        n3_prod      = twcp_pkg::PROD_W'(r2_diff) * twcp_pkg::PROD_W'(r2_ht);
        n3_sd.region = r2_region;
        n3_sd.fill   = r2_fill;
        n3_sd.face   = (r2_region == twcp_pkg::REGION_WALL) ? r2_face : '0;
        n3_sd.tcol   = (r2_region == twcp_pkg::REGION_WALL) ? r2_tcol : '0;
        n3_sd.fb     = r2_fb;
        n3_sd.ht     = r2_ht;
        // quotient reaches the height exactly when the offset reaches the span
        n3_sd.sat    = r2_diff >= r2_span;
        n3_dv.rem    = n3_prod[twcp_pkg::PROD_W-1:TW];
        n3_dv.lo     = n3_prod[TW-1:0];
        n3_dv.q      = '0;
        n3_dv.span   = r2_span;
    end

    always_comb begin
        v_t = '0;
        for (int j = 0; j < NS; j++) begin
            n_dv[j] = r_dv[j];
            for (int s = 0; s < twcp_pkg::DIV_STEPS; s++) begin
                v_t        = {n_dv[j].rem, n_dv[j].lo[TW-1]};
                n_dv[j].lo = {n_dv[j].lo[TW-2:0], 1'b0};
                if (v_t >= {1'b0, n_dv[j].span}) begin
                    v_t       = v_t - {1'b0, n_dv[j].span};
                    n_dv[j].q = {n_dv[j].q[TW-2:0], 1'b1};
                end else begin
                    n_dv[j].q = {n_dv[j].q[TW-2:0], 1'b0};
                end
                n_dv[j].rem = v_t[DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= NS; j++) begin
                r_vl[j] <= 1'b0;
            end
        end else if (w_en) begin
            r_vl[0] <= r2_valid;
            for (int j = 0; j < NS; j++) begin
                r_vl[j+1] <= r_vl[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= n3_sd;
            r_dv[0] <= n3_dv;
            for (int j = 0; j < NS; j++) begin
                r_sd[j+1] <= r_sd[j];
                r_dv[j+1] <= n_dv[j];
            end
        end
    end

    // output stage
    logic [TW-1:0] n_trow;

    always_comb begin
        priority if (r_sd[NS].region != twcp_pkg::REGION_WALL || r_sd[NS].ht == '0) begin
            n_trow = '0;
        end else if (r_sd[NS].sat) begin
            n_trow = r_sd[NS].ht - 1'b1;
        end else begin
            n_trow = r_dv[NS].q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_vl[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_region     <= r_sd[NS].region;
            o_fill_color <= r_sd[NS].fill;
            o_tex_face   <= r_sd[NS].face;
            o_tex_col    <= r_sd[NS].tcol;
            o_tex_row    <= n_trow;
            o_fb_offset  <= r_sd[NS].fb;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

[sim/tb_top.sv]
// self-checking testbench for textured_wall_column_pixel: directed and random items
// under random input gaps and output stalls, checked against an in-bench pixel predictor
// depends on twcp_pkg and rtl/textured_wall_column_pixel.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import twcp_pkg::*;

    localparam int WATCH_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int RAND_PHASES = 7;
    localparam int PHASE_ITEMS = 146;

    typedef struct packed {
        logic [ROW_W-1:0]         column;
        logic [ROW_W-1:0]         row;
        logic [SPAN_W-1:0]        span;
        logic [FACE_W-1:0]        face;
        logic signed [TEX_W-1:0]  hit;
    } t_pixel_req;

    typedef struct packed {
        logic [1:0]         region;
        logic [COLOR_W-1:0] fill;
        logic [FACE_W-1:0]  face;
        logic [TEX_W-1:0]   tcol;
        logic [TEX_W-1:0]   trow;
        logic [FB_W-1:0]    fb;
    } t_pixel_res;

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = CFG_SCREEN_ROWS;
    logic [PACK_W-1:0]         i_cfg_data = '0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [ROW_W-1:0]          i_column = '0;
    logic [ROW_W-1:0]          i_row = '0;
    logic [SPAN_W-1:0]         i_wall_span = '0;
    logic [FACE_W-1:0]         i_face = '0;
    logic signed [TEX_W-1:0]   i_hit_coord = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [1:0]                o_region;
    logic [COLOR_W-1:0]        o_fill_color;
    logic [FACE_W-1:0]         o_tex_face;
    logic [TEX_W-1:0]          o_tex_col;
    logic [TEX_W-1:0]          o_tex_row;
    logic [FB_W-1:0]           o_fb_offset;

    textured_wall_column_pixel DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_column     (i_column),
        .i_row        (i_row),
        .i_wall_span  (i_wall_span),
        .i_face       (i_face),
        .i_hit_coord  (i_hit_coord),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_region     (o_region),
        .o_fill_color (o_fill_color),
        .o_tex_face   (o_tex_face),
        .o_tex_col    (o_tex_col),
        .o_tex_row    (o_tex_row),
        .o_fb_offset  (o_fb_offset)
    );

    logic [ROW_W-1:0]   cfg_rows    = RST_SCREEN_ROWS;
    logic [COLOR_W-1:0] cfg_ceiling = '0;
    logic [COLOR_W-1:0] cfg_floor   = '0;
    logic [LINE_W-1:0]  cfg_line    = RST_LINE_BYTES;
    logic [PACK_W-1:0]  cfg_widths  = RST_FACE_DIMS;
    logic [PACK_W-1:0]  cfg_heights = RST_FACE_DIMS;

    t_pixel_req pending_px[$];
    t_pixel_res expected_px[$];
    t_pixel_req cur_px;

    bit calm = 1'b0;
    int send_gap;
    int stall_gap;
    int idle_cycles;
    int mismatches;
    int items_in;
    int n_ceiling;
    int n_wall;
    int n_floor;
    int settings_used;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_pixel_res shade_pixel(t_pixel_req px);
        t_pixel_res res;
        int top;
        int bottom;
        int y;
        longint unsigned w;
        longint unsigned ht;
        longint unsigned span;
        longint unsigned q;
        longint unsigned acc;
        res = '0;
        y = int'(px.row);
        top = (int'(cfg_rows) - int'(px.span)) / 2;
        bottom = (int'(cfg_rows) + int'(px.span)) / 2;
        acc = 64'(px.row) * 64'(cfg_line) + 64'(px.column) * 64'(BYTES_PER_PIXEL);
        res.fb = acc[FB_W-1:0];
        if (y < top) begin
            res.region = REGION_CEILING;
            res.fill = cfg_ceiling;
        end else if (y <= bottom) begin
            w = 64'(cfg_widths[px.face*TEX_W +: TEX_W]);
            ht = 64'(cfg_heights[px.face*TEX_W +: TEX_W]);
            span = longint'(bottom - top);
            res.region = REGION_WALL;
            res.face = px.face;
            if (px.hit[TEX_W-1] == 1'b0) begin
                acc = (longint'(px.hit[TEX_W-2:0]) % TILE) * w / TILE;
                res.tcol = acc[TEX_W-1:0];
            end
            if (ht == 0) begin
                res.trow = '0;
            end else if (span == 0) begin
                res.trow = TEX_W'(ht - 1);
            end else begin
                q = longint'(y - top) * ht / span;
                res.trow = (q > ht - 1) ? TEX_W'(ht - 1) : TEX_W'(q);
            end
        end else begin
            res.region = REGION_FLOOR;
            res.fill = cfg_floor;
        end
        return res;
    endfunction

    function automatic logic [TEX_W-1:0] pick_dim();
        case ($urandom_range(0, 6))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'd64;
            4: return TEX_W'($urandom_range(1, 256));
            default: return TEX_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_pixel_req random_px();
        t_pixel_req px;
        int lim;
        int pick;
        px.column = ROW_W'($urandom_range(0, 2047));
        px.face = FACE_W'($urandom_range(0, 3));
        lim = int'(cfg_rows) + int'(cfg_rows) / 4 + 2;
        if (lim > 2047) lim = 2047;
        px.row = ROW_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, lim)
                                                     : $urandom_range(0, 2047));
        pick = $urandom_range(0, 99);
        lim = 2 * int'(cfg_rows) + 2;
        if (pick < 15) px.span = SPAN_W'($urandom_range(0, 3));
        else if (pick < 65) px.span = SPAN_W'($urandom_range(0, lim));
        else if (pick < 85) px.span = SPAN_W'($urandom_range(0, cfg_rows));
        else px.span = SPAN_W'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 60) px.hit = TEX_W'($urandom_range(0, 65535));
        else if (pick < 80) px.hit = TEX_W'($urandom_range(0, 127));
        else px.hit = TEX_W'($urandom_range(65472, 65535));
        return px;
    endfunction

    task automatic report_fail(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t ns: %s", $realtime, msg);
    endtask

    task automatic push_px(input logic [ROW_W-1:0] col, input logic [ROW_W-1:0] row,
                           input logic [SPAN_W-1:0] span, input logic [FACE_W-1:0] face,
                           input logic [TEX_W-1:0] hit);
        t_pixel_req px;
        px.column = col;
        px.row = row;
        px.span = span;
        px.face = face;
        px.hit = hit;
        pending_px.push_back(px);
    endtask

    task automatic drain();
        while (pending_px.size() != 0 || expected_px.size() != 0 || i_valid)
            @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PACK_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SCREEN_ROWS:  cfg_rows = data[ROW_W-1:0];
            CFG_CEILING:      cfg_ceiling = data[COLOR_W-1:0];
            CFG_FLOOR:        cfg_floor = data[COLOR_W-1:0];
            CFG_LINE_BYTES:   cfg_line = data[LINE_W-1:0];
            CFG_FACE_WIDTHS:  cfg_widths = data;
            CFG_FACE_HEIGHTS: cfg_heights = data;
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic [ROW_W-1:0] rows, input logic [COLOR_W-1:0] ceil_c,
                                  input logic [COLOR_W-1:0] floor_c, input logic [LINE_W-1:0] line,
                                  input logic [PACK_W-1:0] widths, input logic [PACK_W-1:0] heights);
        drain();
        repeat (4) @(posedge i_clk);
        put_reg(CFG_SCREEN_ROWS, PACK_W'(rows));
        put_reg(CFG_CEILING, PACK_W'(ceil_c));
        put_reg(CFG_FLOOR, PACK_W'(floor_c));
        put_reg(CFG_LINE_BYTES, PACK_W'(line));
        put_reg(CFG_FACE_WIDTHS, widths);
        put_reg(CFG_FACE_HEIGHTS, heights);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_px.push_back(shade_pixel(cur_px));
                items_in++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_px.size() != 0) begin
                    cur_px = pending_px.pop_front();
                    i_column <= cur_px.column;
                    i_row <= cur_px.row;
                    i_wall_span <= cur_px.span;
                    i_face <= cur_px.face;
                    i_hit_coord <= cur_px.hit;
                    i_valid <= 1'b1;
                    send_gap <= idle_len();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pixel_res got;
        t_pixel_res want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                got.region = o_region;
                got.fill = o_fill_color;
                got.face = o_tex_face;
                got.tcol = o_tex_col;
                got.trow = o_tex_row;
                got.fb = o_fb_offset;
                case (got.region)
                    REGION_CEILING: n_ceiling++;
                    REGION_WALL:    n_wall++;
                    default:        n_floor++;
                endcase
                if (expected_px.size() == 0) begin
                    report_fail("result with no item pending");
                end else begin
                    want = expected_px.pop_front();
                    if (got !== want)
                        report_fail($sformatf({"mismatch exp/got: region %0d/%0d fill %h/%h ",
                            "face %0d/%0d col %0d/%0d row %0d/%0d fb %h/%h"},
                            want.region, got.region, want.fill, got.fill, want.face, got.face,
                            want.tcol, got.tcol, want.trow, got.trow, want.fb, got.fb));
                end
            end
            if (stall_gap > 0) begin
                i_stall <= 1'b1;
                stall_gap <= stall_gap - 1;
            end else begin
                i_stall <= 1'b0;
                stall_gap <= idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (i_rst_n);
        while (idle_cycles < WATCH_LIMIT) @(posedge i_clk);
        $display("[textured_wall_column_pixel] ERROR");
        $finish;
    end

    initial begin
        int ph;
        int k;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: 480 rows, 64x64 textures
        push_px(11'd0,    11'd0,    16'd100,   2'd0, 16'd10);
        push_px(11'd1,    11'd479,  16'd100,   2'd0, 16'd10);
        push_px(11'd2,    11'd190,  16'd100,   2'd1, 16'd20);
        push_px(11'd3,    11'd290,  16'd100,   2'd2, 16'd30);
        push_px(11'd4,    11'd240,  16'd0,     2'd3, 16'd5);
        push_px(11'd5,    11'd240,  16'd100,   2'd0, 16'hFFFF);
        push_px(11'd6,    11'd240,  16'd100,   2'd1, 16'h8000);
        push_px(11'd7,    11'd240,  16'd100,   2'd2, 16'h7FFF);
        push_px(11'd8,    11'd240,  16'd100,   2'd3, 16'd64);
        push_px(11'd2047, 11'd2047, 16'hFFFF,  2'd3, 16'd63);
        push_px(11'd9,    11'd2047, 16'd0,     2'd0, 16'd1);
        push_px(11'd10,   11'd200,  16'd300,   2'd0, 16'd33);
        push_px(11'd11,   11'd201,  16'd300,   2'd1, 16'd33);
        push_px(11'd12,   11'd202,  16'd300,   2'd2, 16'd33);
        push_px(11'd13,   11'd203,  16'd300,   2'd3, 16'd33);

        // mixed face sizes with zero width and zero height lanes
        write_settings(11'd2047, 24'hFFFFFF, 24'h5A5A5A, 16'hFFFF,
                       {16'd64, 16'd1, 16'd0, 16'hFFFF}, {16'd3, 16'd1, 16'hFFFF, 16'd0});
        push_px(11'd100,  11'd1000, 16'd100,   2'd1, 16'd50);
        push_px(11'd101,  11'd1073, 16'd100,   2'd0, 16'd63);
        push_px(11'd2047, 11'd2047, 16'd0,     2'd2, 16'd1);
        push_px(11'd0,    11'd0,    16'd0,     2'd0, 16'd1);
        push_px(11'd102,  11'd1023, 16'd0,     2'd2, 16'd17);
        push_px(11'd103,  11'd1073, 16'd100,   2'd3, 16'd40);

        // zero screen rows: negative halves truncate toward zero
        write_settings(11'd0, 24'h123456, 24'hFEDCBA, 16'd0, RST_FACE_DIMS, RST_FACE_DIMS);
        push_px(11'd20,   11'd0,    16'd0,     2'd0, 16'd7);
        push_px(11'd21,   11'd5,    16'd1,     2'd1, 16'd7);
        push_px(11'd22,   11'd1,    16'd3,     2'd2, 16'd7);
        push_px(11'd23,   11'd0,    16'd3,     2'd3, 16'd7);
        drain();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            calm = (ph % 3 == 2);
            if (ph == 0)
                write_settings(11'd2047, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, '1, '1);
            else if (ph == 1)
                write_settings(11'd1, 24'h0, 24'h0, 16'd0, '0, '0);
            else if (ph == 2)
                write_settings(RST_SCREEN_ROWS, 24'h0, 24'h0, RST_LINE_BYTES,
                               RST_FACE_DIMS, RST_FACE_DIMS);
            else
                write_settings(ROW_W'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 2047)
                                                                   : $urandom_range(16, 200)),
                               COLOR_W'($urandom_range(0, 24'hFFFFFF)),
                               COLOR_W'($urandom_range(0, 24'hFFFFFF)),
                               LINE_W'($urandom_range(0, 65535)),
                               {pick_dim(), pick_dim(), pick_dim(), pick_dim()},
                               {pick_dim(), pick_dim(), pick_dim(), pick_dim()});
            for (k = 0; k < PHASE_ITEMS; k++) begin
                pending_px.push_back(random_px());
                // sender holds off mid-phase until the pipeline is empty
                if (k == PHASE_ITEMS / 2) drain();
            end
            drain();
        end
        calm = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_px.size() != 0)
            report_fail($sformatf("%0d results never arrived", expected_px.size()));

        $display("sent %0d pixels under %0d register settings; %0d mismatches",
                 items_in, settings_used + 1, mismatches);
        $display("results by row class: %0d ceiling, %0d wall, %0d floor",
                 n_ceiling, n_wall, n_floor);
        if (mismatches == 0)
            $display("[textured_wall_column_pixel] OK");
        else
            $display("[textured_wall_column_pixel] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/twcp_pkg.sv
rtl/textured_wall_column_pixel.sv
sim/tb_top.sv
